// ===== rtl/utf8v_pkg.sv =====
// Shared types and codes for the UTF-8 sequence validator.
`default_nettype none

package utf8v_pkg;

	// Byte class codes
	typedef logic [3:0] byte_class_t;

	localparam byte_class_t CLS_ASCII    = 4'd0;   // 00-7F
	localparam byte_class_t CLS_CONT_LO  = 4'd1;   // 80-8F, C0, C1
	localparam byte_class_t CLS_LEAD2    = 4'd2;   // C2-DF
	localparam byte_class_t CLS_LEAD3    = 4'd3;   // E1-EC, EE, EF
	localparam byte_class_t CLS_ED       = 4'd4;   // ED
	localparam byte_class_t CLS_F4       = 4'd5;   // F4
	localparam byte_class_t CLS_LEAD4    = 4'd6;   // F1-F3
	localparam byte_class_t CLS_CONT_HI  = 4'd7;   // A0-BF
	localparam byte_class_t CLS_BAD      = 4'd8;   // F5-FF
	localparam byte_class_t CLS_CONT_MID = 4'd9;   // 90-9F
	localparam byte_class_t CLS_E0       = 4'd10;  // E0
	localparam byte_class_t CLS_F0       = 4'd11;  // F0

	// Result status codes
	typedef enum logic [1:0] {
		STATUS_PENDING   = 2'd0,
		STATUS_COMPLETE  = 2'd1,
		STATUS_INVALID   = 2'd2,
		STATUS_TRUNCATED = 2'd3
	} status_t;

	// Result of one byte, passed from the step logic to the output register
	typedef struct packed {
		logic [1:0] end_index;
		status_t    status;
	} result_t;

	localparam int TDATA_W = 8;

endpackage : utf8v_pkg

`default_nettype wire

// ===== rtl/utf8v_classify.sv =====
// Byte classifier: sorts a raw byte into one of the validator's byte classes.
`default_nettype none

module utf8v_classify (
	input  wire logic [7:0]            data_byte,
	output utf8v_pkg::byte_class_t     byte_class
);

	// Decode byte ranges in ascending order
	always_comb begin
		if (data_byte < 8'h80) begin
			byte_class = utf8v_pkg::CLS_ASCII;
		end else if (data_byte < 8'h90) begin
			byte_class = utf8v_pkg::CLS_CONT_LO;
		end else if (data_byte < 8'hA0) begin
			byte_class = utf8v_pkg::CLS_CONT_MID;
		end else if (data_byte < 8'hC0) begin
			byte_class = utf8v_pkg::CLS_CONT_HI;
		end else if (data_byte < 8'hC2) begin
			byte_class = utf8v_pkg::CLS_CONT_LO;
		end else if (data_byte < 8'hE0) begin
			byte_class = utf8v_pkg::CLS_LEAD2;
		end else if (data_byte == 8'hE0) begin
			byte_class = utf8v_pkg::CLS_E0;
		end else if (data_byte == 8'hED) begin
			byte_class = utf8v_pkg::CLS_ED;
		end else if (data_byte < 8'hF0) begin
			byte_class = utf8v_pkg::CLS_LEAD3;
		end else if (data_byte == 8'hF0) begin
			byte_class = utf8v_pkg::CLS_F0;
		end else if (data_byte < 8'hF4) begin
			byte_class = utf8v_pkg::CLS_LEAD4;
		end else if (data_byte == 8'hF4) begin
			byte_class = utf8v_pkg::CLS_F4;
		end else begin
			byte_class = utf8v_pkg::CLS_BAD;
		end
	end

endmodule : utf8v_classify

`default_nettype wire

// ===== rtl/utf8v_step.sv =====
// Decoder automaton: state registers, transition table and status decision.
`default_nettype none

module utf8v_step (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   advance,     // item leaves the input stage
	input  wire utf8v_pkg::byte_class_t byte_class,
	input  wire logic                   last_byte,
	output utf8v_pkg::result_t          result
);

	// Decoder states, named by what the next byte must be
	typedef enum logic [7:0] {
		ST_START = 8'b0000_0001,  // between sequences
		ST_NEED1 = 8'b0000_0010,  // one continuation left
		ST_NEED2 = 8'b0000_0100,  // two continuations left
		ST_E0    = 8'b0000_1000,  // after E0: A0-BF, then one more
		ST_ED    = 8'b0001_0000,  // after ED: 80-9F, C0, C1, then one more
		ST_F0    = 8'b0010_0000,  // after F0: 90-BF, then two more
		ST_NEED3 = 8'b0100_0000,  // three continuations left
		ST_F4    = 8'b1000_0000   // after F4: 80-8F, C0, C1, then two more
	} dec_state_t;

	dec_state_t state_q;
	logic [1:0] pos_q;

	dec_state_t next_st;
	logic       hit;
	utf8v_pkg::status_t status;

	// Look up the transition for the current state and byte class
	always_comb begin
		hit     = 1'b0;
		next_st = ST_START;
		case (state_q)
			ST_START: begin
				hit = 1'b1;
				case (byte_class)
					utf8v_pkg::CLS_ASCII: next_st = ST_START;
					utf8v_pkg::CLS_LEAD2: next_st = ST_NEED1;
					utf8v_pkg::CLS_LEAD3: next_st = ST_NEED2;
					utf8v_pkg::CLS_F4:    next_st = ST_F4;
					utf8v_pkg::CLS_LEAD4: next_st = ST_NEED3;
					utf8v_pkg::CLS_F0:    next_st = ST_F0;
					utf8v_pkg::CLS_E0:    next_st = ST_E0;
					utf8v_pkg::CLS_ED:    next_st = ST_ED;
					default:              hit     = 1'b0;
				endcase
			end
			ST_F4: begin
				hit     = (byte_class == utf8v_pkg::CLS_CONT_LO);
				next_st = ST_NEED2;
			end
			ST_NEED3: begin
				hit     = byte_class inside {utf8v_pkg::CLS_CONT_LO, utf8v_pkg::CLS_CONT_HI,
				                              utf8v_pkg::CLS_CONT_MID};
				next_st = ST_NEED2;
			end
			ST_F0: begin
				hit     = byte_class inside {utf8v_pkg::CLS_CONT_HI, utf8v_pkg::CLS_CONT_MID};
				next_st = ST_NEED2;
			end
			ST_E0: begin
				hit     = (byte_class == utf8v_pkg::CLS_CONT_HI);
				next_st = ST_NEED1;
			end
			ST_ED: begin
				hit     = byte_class inside {utf8v_pkg::CLS_CONT_LO, utf8v_pkg::CLS_CONT_MID};
				next_st = ST_NEED1;
			end
			ST_NEED2: begin
				hit     = byte_class inside {utf8v_pkg::CLS_CONT_LO, utf8v_pkg::CLS_CONT_HI,
				                              utf8v_pkg::CLS_CONT_MID};
				next_st = ST_NEED1;
			end
			ST_NEED1: begin
				hit     = byte_class inside {utf8v_pkg::CLS_CONT_LO, utf8v_pkg::CLS_CONT_HI,
				                              utf8v_pkg::CLS_CONT_MID};
				next_st = ST_START;
			end
			default: begin
				hit     = 1'b0;
				next_st = ST_START;
			end
		endcase
	end

	// Decide the status; invalid wins over truncated
	always_comb begin
		if (!hit) begin
			status = utf8v_pkg::STATUS_INVALID;
		end else if (next_st == ST_START) begin
			status = utf8v_pkg::STATUS_COMPLETE;
		end else if (last_byte) begin
			status = utf8v_pkg::STATUS_TRUNCATED;
		end else begin
			status = utf8v_pkg::STATUS_PENDING;
		end
	end

	assign result.status    = status;
	assign result.end_index = pos_q;

	// Advance the automaton; return to start after any finished sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_START;
			pos_q   <= 2'd0;
		end else if (advance) begin
			if (status == utf8v_pkg::STATUS_PENDING) begin
				state_q <= next_st;
				pos_q   <= pos_q + 2'd1;
			end else begin
				state_q <= ST_START;
				pos_q   <= 2'd0;
			end
		end
	end

	// Byte position is zero exactly between sequences
	a_pos_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q == 2'd0) == (state_q == ST_START))
		else $error("byte position out of step with decoder state");

	// A finished byte sends the automaton back to start
	a_restart_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && status != utf8v_pkg::STATUS_PENDING) |=>
		(state_q == ST_START && pos_q == 2'd0))
		else $error("decoder did not return to start");

	// No sequence stays open past its fourth byte
	a_no_pending_at_four: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && pos_q == 2'd3) |-> (status != utf8v_pkg::STATUS_PENDING))
		else $error("sequence still pending at fourth byte");

endmodule : utf8v_step

`default_nettype wire

// ===== rtl/utf8_sequence_validator.sv =====
// Top level of the UTF-8 sequence validator: input stage, automaton, result register.
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+-------------------------------------
//  s_       | in        | s_tvalid/s_tready | s_tdata[7:0] data_byte, s_tlast last_byte
//  m_       | out       | m_tvalid/m_tready | m_tdata[1:0] status, [3:2] end_index
//
// One byte per cycle sustained while m_tready is high; the result is presented after the input
// transaction has passed through the input register, then the result register.
// The decoder state and byte position update as a byte moves into the result register.
// arst_n clears the automaton to its start state and empties both stages.
// A stalled result holds the input stage; the input stays ready while the result
// register is free or is being taken in the same cycle.
`default_nettype none

module utf8_sequence_validator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic        s_tlast,   // last_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata    // [1:0] status, [3:2] end_index, [7:4] zero
);

	logic               valid_s1;
	logic [7:0]         data_s1;
	logic               last_s1;
	logic               valid_s2;
	utf8v_pkg::result_t res_s2;

	logic                   accept;
	logic                   advance;
	utf8v_pkg::byte_class_t byte_class;
	utf8v_pkg::result_t     result;

	// Move the held byte on when the result register is free or draining
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;

	// Hold the input transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	utf8v_classify u_classify (
		.data_byte  (data_s1),
		.byte_class (byte_class)
	);

	utf8v_step u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.byte_class (byte_class),
		.last_byte  (last_s1),
		.result     (result)
	);

	// Capture the result; drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(utf8v_pkg::TDATA_W - $bits(utf8v_pkg::result_t)){1'b0}}, res_s2};

endmodule : utf8_sequence_validator

`default_nettype wire
